// ----- src/sflh_pkg.sv -----
// ----------------------------------------------------------------------------
// sflh_pkg
// Shared types, constants and level tables for the stepped fan level block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sflh_pkg;

   localparam int TABLE_ROWS         = 8;
   localparam int LEVEL_W            = 3;
   localparam int TEMP_W             = 8;
   localparam int RPM_W              = 16;
   localparam int CHAN_W             = 2;
   localparam int PSTATE_W           = 2;
   localparam int NUM_LEVELS_DEFAULT = 8;

   localparam logic [PSTATE_W-1:0] PSTATE_RUN     = 2'd0;
   localparam logic [PSTATE_W-1:0] PSTATE_SUSPEND = 2'd1;

   localparam logic [CHAN_W-1:0] CHAN_TABLE = 2'd0;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture an accepted item
      logic step;    // move the working level by one
      logic commit;  // update state and present the result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_more;  // the working level still has to move
      logic out_free;   // output register can take a result this cycle
   } status_type;

   // trigger point: level goes up while the sample is above it
   function automatic logic signed [TEMP_W-1:0] trig_pt(input logic [LEVEL_W-1:0] lvl);
      logic signed [TEMP_W-1:0] t;
      case (lvl)
         3'd0:    t = 8'sd40;
         3'd1:    t = 8'sd42;
         3'd2:    t = 8'sd43;
         3'd3:    t = 8'sd44;
         3'd4:    t = 8'sd45;
         3'd5:    t = 8'sd46;
         3'd6:    t = 8'sd47;
         default: t = 8'sd75;
      endcase
      return t;
   endfunction

   // release point: level goes down while the sample is below it
   function automatic logic signed [TEMP_W-1:0] rel_pt(input logic [LEVEL_W-1:0] lvl);
      logic signed [TEMP_W-1:0] t;
      case (lvl)
         3'd0:    t = 8'sd0;
         3'd1:    t = 8'sd40;
         3'd2:    t = 8'sd42;
         3'd3:    t = 8'sd43;
         3'd4:    t = 8'sd44;
         3'd5:    t = 8'sd45;
         3'd6:    t = 8'sd46;
         default: t = 8'sd72;
      endcase
      return t;
   endfunction

   function automatic logic [RPM_W-1:0] rpm_tab(input logic [LEVEL_W-1:0] lvl);
      logic [RPM_W-1:0] r;
      case (lvl)
         3'd0:    r = 16'd0;
         3'd1:    r = 16'd1800;
         3'd2:    r = 16'd2000;
         3'd3:    r = 16'd2200;
         3'd4:    r = 16'd2500;
         3'd5:    r = 16'd2800;
         3'd6:    r = 16'd3000;
         default: r = 16'd3200;
      endcase
      return r;
   endfunction

endpackage

// ----- src/sflh_ctrl.sv -----
// ----------------------------------------------------------------------------
// sflh_ctrl
// Sequencer: takes an item, steps the level walk, then commits the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sflh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sflh_pkg::status_type status,
   output sflh_pkg::cmd_type    cmd
);
   import sflh_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_more) begin
               cmd.step = 1'b1;
            end else if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/sflh_dp.sv -----
// ----------------------------------------------------------------------------
// sflh_dp
// Datapath: item capture, fan level state, trigger/release comparator walk, output reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sflh_dp #(
   parameter int NUM_LEVELS = sflh_pkg::NUM_LEVELS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sflh_pkg::cmd_type                     cmd,
   output sflh_pkg::status_type                  status,
   input  logic signed [sflh_pkg::TEMP_W-1:0]    req_temperature,
   input  logic [sflh_pkg::CHAN_W-1:0]           req_fan_channel,
   input  logic [sflh_pkg::PSTATE_W-1:0]         req_power_state,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_target_written,
   output logic [sflh_pkg::RPM_W-1:0]            rsp_fan_rpm,
   output logic [sflh_pkg::LEVEL_W-1:0]          rsp_fan_level
);
   import sflh_pkg::*;

   // levels beyond the table act as the table size
   localparam int EFF_LEVELS = (NUM_LEVELS > TABLE_ROWS) ? TABLE_ROWS : NUM_LEVELS;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(EFF_LEVELS - 1);

   // state
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic signed [TEMP_W-1:0] last_temp_ff, last_temp_in;

   // item under work
   logic signed [TEMP_W-1:0] temp_ff;
   logic [CHAN_W-1:0]        chan_ff;
   logic [PSTATE_W-1:0]      pstate_ff;
   logic                     down_ff, up_ff;
   logic [LEVEL_W-1:0]       work_ff, work_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     written_ff;
   logic [RPM_W-1:0]         rpm_ff;
   logic [LEVEL_W-1:0]       lvl_out_ff;

   logic running;
   logic move_down, move_up;

   assign running   = (pstate_ff == PSTATE_RUN);
   assign move_down = down_ff && (work_ff != '0) && (temp_ff < rel_pt(work_ff));
   assign move_up   = up_ff && (work_ff < TOP_LEVEL) && (temp_ff > trig_pt(work_ff));

   assign status.walk_more = running && (move_down || move_up);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      work_in = work_ff;
      if (cmd.load) begin
         work_in = (level_ff > TOP_LEVEL) ? TOP_LEVEL : level_ff;
      end else if (cmd.step) begin
         work_in = move_up ? work_ff + 1'b1 : work_ff - 1'b1;
      end
   end

   always_comb begin
      level_in     = level_ff;
      last_temp_in = last_temp_ff;
      if (cmd.commit && running) begin
         level_in     = work_ff;
         last_temp_in = temp_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         last_temp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         last_temp_ff <= last_temp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (cmd.load) begin
         temp_ff   <= req_temperature;
         chan_ff   <= req_fan_channel;
         pstate_ff <= req_power_state;
         // direction is fixed for the whole walk
         down_ff   <= (req_temperature < last_temp_ff);
         up_ff     <= (req_temperature > last_temp_ff);
      end
      if (cmd.commit) begin
         written_ff <= running || (pstate_ff == PSTATE_SUSPEND);
         rpm_ff     <= (running && chan_ff == CHAN_TABLE) ? rpm_tab(work_ff) : '0;
         lvl_out_ff <= running ? work_ff : level_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_written = written_ff;
   assign rsp_fan_rpm        = rpm_ff;
   assign rsp_fan_level      = lvl_out_ff;

endmodule

// ----- src/stepped_fan_level_hysteresis.sv -----
// ----------------------------------------------------------------------------
// stepped_fan_level_hysteresis
// Fan level with hysteresis: one temperature sample in, one RPM target out.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// req     | in  | req_valid/stall   | temperature, fan_channel, power_state
// rsp     | out | rsp_valid/stall   | target_written, fan_rpm, fan_level
//
// An item is captured, then walks n levels (n = 0 to 7), one level step at a
// time through the trigger/release comparators, and then commits. A new item
// is taken once the previous one has committed.
// The result sits in an output register; a stalled rsp holds only the commit.
// Synchronous reset clears level and previous temperature to zero and drops rsp_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepped_fan_level_hysteresis #(
   parameter int NUM_LEVELS = sflh_pkg::NUM_LEVELS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sflh_pkg::TEMP_W-1:0]    req_temperature,
   input  logic [sflh_pkg::CHAN_W-1:0]           req_fan_channel,
   input  logic [sflh_pkg::PSTATE_W-1:0]         req_power_state,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_target_written,
   output logic [sflh_pkg::RPM_W-1:0]            rsp_fan_rpm,
   output logic [sflh_pkg::LEVEL_W-1:0]          rsp_fan_level
);
   import sflh_pkg::*;

   cmd_type    cmd;
   status_type status;

   sflh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sflh_dp #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_temperature    (req_temperature),
      .req_fan_channel    (req_fan_channel),
      .req_power_state    (req_power_state),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_target_written (rsp_target_written),
      .rsp_fan_rpm        (rsp_fan_rpm),
      .rsp_fan_level      (rsp_fan_level)
   );

endmodule
